// File: rtl/kdb_pkg.sv
// shared types, register indexes, event codes and reset values for the key scanner
// no dependencies
`default_nettype none

package kdb_pkg;

    localparam int NUM_KEYS_DEF = 8;
    localparam int PIN_W        = 8;
    localparam int TICK_W       = 16;
    localparam int KEY_W        = 3;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd4;

    localparam logic [KIND_W-1:0] EV_CLICK  = 2'd0;
    localparam logic [KIND_W-1:0] EV_LONG   = 2'd1;
    localparam logic [KIND_W-1:0] EV_REPEAT = 2'd2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd5;
    localparam logic [TICK_W-1:0] LONG_RST     = 16'd100;
    localparam logic [TICK_W-1:0] REPEAT_RST   = 16'd20;

    typedef struct packed {
        logic [PIN_W-1:0]  enable;
        logic [PIN_W-1:0]  active_low;
        logic [TICK_W-1:0] debounce;
        logic [TICK_W-1:0] long_click;
        logic [TICK_W-1:0] repeat_ticks;
    } cfg_t;

    // key state wipe request, with the debounce value to load
    typedef struct packed {
        logic              clear;
        logic [TICK_W-1:0] ticks;
    } clear_t;

endpackage

`default_nettype wire

// File: rtl/kdb_regs.sv
// configuration registers of the key scanner and the key state wipe request
// depends on kdb_pkg
`default_nettype none

module kdb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kdb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kdb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output kdb_pkg::cfg_t                         cfg,
    output kdb_pkg::clear_t                       clr
);

    kdb_pkg::cfg_t cfg_reg;
    kdb_pkg::cfg_t cfg_next;
    logic          wr;
    logic          hit;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (wr)
        begin
            unique case (cfg_index)
                kdb_pkg::REG_ENABLE:
                begin
                    cfg_next.enable = cfg_data[kdb_pkg::PIN_W-1:0];
                    hit = 1'b1;
                end
                kdb_pkg::REG_ACTIVE_LOW:
                begin
                    cfg_next.active_low = cfg_data[kdb_pkg::PIN_W-1:0];
                    hit = 1'b1;
                end
                kdb_pkg::REG_DEBOUNCE:
                begin
                    cfg_next.debounce = cfg_data;
                    hit = 1'b1;
                end
                kdb_pkg::REG_LONG:
                begin
                    cfg_next.long_click = cfg_data;
                    hit = 1'b1;
                end
                kdb_pkg::REG_REPEAT:
                begin
                    cfg_next.repeat_ticks = cfg_data;
                    hit = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= '0;
            cfg_reg.active_low   <= '0;
            cfg_reg.debounce     <= kdb_pkg::DEBOUNCE_RST;
            cfg_reg.long_click   <= kdb_pkg::LONG_RST;
            cfg_reg.repeat_ticks <= kdb_pkg::REPEAT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg       = cfg_reg;
    // counters reload with the debounce value in force after this write
    assign clr.clear = hit;
    assign clr.ticks = cfg_next.debounce;

endmodule

`default_nettype wire

// File: rtl/kdb_front.sv
// front end: takes scan ticks, applies pin polarity and queues the key levels
// depends on kdb_pkg
`default_nettype none

module kdb_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [kdb_pkg::PIN_W-1:0]    pin_levels,
    input  wire logic [kdb_pkg::PIN_W-1:0]    active_low,
    output logic                              q_valid,
    output logic [kdb_pkg::PIN_W-1:0]         q_levels,
    input  wire logic                         q_pop
);

    logic [kdb_pkg::PIN_W-1:0] slot_reg [2];
    logic                      wr_ptr_reg;
    logic                      wr_ptr_next;
    logic                      rd_ptr_reg;
    logic                      rd_ptr_next;
    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    logic                      push;
    logic                      pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_levels = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // stored as pressed levels, polarity already corrected
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= pin_levels ^ active_low;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kdb_back.sv
// back end: per-key debounce and click state, one key scanned a cycle unless stalled, event output
// depends on kdb_pkg
`default_nettype none

module kdb_back #(
    parameter int NUM_KEYS = kdb_pkg::NUM_KEYS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire kdb_pkg::cfg_t                 cfg,
    input  wire kdb_pkg::clear_t               clr,
    input  wire logic                          q_valid,
    input  wire logic [kdb_pkg::PIN_W-1:0]     q_levels,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [kdb_pkg::KEY_W-1:0]          key_index,
    output logic [kdb_pkg::KIND_W-1:0]         event_kind,
    output logic                               last_event
);

    localparam int SCAN_KEYS = (NUM_KEYS < 8) ? NUM_KEYS : 8;
    localparam int KW        = (SCAN_KEYS > 1) ? $clog2(SCAN_KEYS) : 1;
    localparam logic [KW-1:0] LAST_KEY = KW'(SCAN_KEYS - 1);
    localparam int TW        = kdb_pkg::TICK_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [KW-1:0]               kidx_reg;
    logic [KW-1:0]               kidx_next;
    logic [kdb_pkg::PIN_W-1:0]   levels_reg;

    logic [SCAN_KEYS-1:0]        settled_reg;
    logic [SCAN_KEYS-1:0]        confirmed_reg;
    logic [SCAN_KEYS-1:0]        rel_pend_reg;
    logic [SCAN_KEYS-1:0]        repeating_reg;
    logic [TW-1:0]               tick_reg [SCAN_KEYS];

    logic                        pend_valid_reg;
    logic [kdb_pkg::KEY_W-1:0]   pend_key_reg;
    logic [kdb_pkg::KIND_W-1:0]  pend_kind_reg;

    logic                        out_valid_reg;
    logic [kdb_pkg::KEY_W-1:0]   out_key_reg;
    logic [kdb_pkg::KIND_W-1:0]  out_kind_reg;
    logic                        out_last_reg;

    logic [kdb_pkg::KEY_W-1:0]   kn;
    logic                        en;
    logic                        lvl;
    logic                        s_cur;
    logic                        c_cur;
    logic                        rp_cur;
    logic                        rep_cur;
    logic [TW-1:0]               t_cur;
    logic [TW-1:0]               t_dec;
    logic [TW-1:0]               t_inc;
    logic                        s_next;
    logic                        c_next;
    logic                        rp_next;
    logic                        rep_next;
    logic [TW-1:0]               t_next;
    logic                        fire;
    logic [kdb_pkg::KIND_W-1:0]  kind;

    logic                        out_free;
    logic                        step;
    logic                        push_mid;
    logic                        push_last;

    assign kn      = kdb_pkg::KEY_W'(kidx_reg);
    assign en      = cfg.enable[kn];
    assign lvl     = levels_reg[kn];
    assign s_cur   = settled_reg[kidx_reg];
    assign c_cur   = confirmed_reg[kidx_reg];
    assign rp_cur  = rel_pend_reg[kidx_reg];
    assign rep_cur = repeating_reg[kidx_reg];
    assign t_cur   = tick_reg[kidx_reg];
    assign t_dec   = t_cur - TW'(1);
    assign t_inc   = t_cur + TW'(1);

    // next state of the key under scan
    always_comb
    begin
        s_next   = s_cur;
        c_next   = c_cur;
        rp_next  = rp_cur;
        rep_next = rep_cur;
        t_next   = t_cur;
        fire     = 1'b0;
        kind     = kdb_pkg::EV_CLICK;
        if (en)
        begin
            if (lvl != s_cur)
            begin
                // countdown is kept across bounces; here only a confirmed release reloads it
                if (!c_cur)
                begin
                    t_next = t_dec;
                end
                if (c_cur || (t_dec == '0))
                begin
                    c_next = 1'b1;
                    if (lvl)
                    begin
                        rp_next = 1'b1;
                    end
                    s_next = lvl;
                end
            end
            else if (c_cur)
            begin
                if (lvl)
                begin
                    if (rep_cur)
                    begin
                        if (t_dec == '0)
                        begin
                            fire   = 1'b1;
                            kind   = kdb_pkg::EV_REPEAT;
                            t_next = cfg.repeat_ticks;
                        end
                        else
                        begin
                            t_next = t_dec;
                        end
                    end
                    else
                    begin
                        if (t_inc >= cfg.long_click)
                        begin
                            fire     = 1'b1;
                            kind     = kdb_pkg::EV_LONG;
                            rep_next = 1'b1;
                            t_next   = cfg.repeat_ticks;
                        end
                        else
                        begin
                            t_next = t_inc;
                        end
                    end
                end
                else
                begin
                    if (rp_cur)
                    begin
                        if (!rep_cur)
                        begin
                            fire = 1'b1;
                            kind = kdb_pkg::EV_CLICK;
                        end
                        rep_next = 1'b0;
                        rp_next  = 1'b0;
                    end
                    c_next = 1'b0;
                    t_next = cfg.debounce;
                end
            end
        end
    end

    // one event is held back so the final one of a tick can carry the last flag
    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = (state_reg == ST_SCAN) && (!fire || !pend_valid_reg || out_free);
    assign push_mid  = step && fire && pend_valid_reg;
    assign push_last = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        kidx_next  = kidx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_SCAN;
                    kidx_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    if (kidx_reg == LAST_KEY)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        kidx_next = kidx_reg + KW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kidx_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kidx_reg  <= kidx_next;
            if (step && fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push_last)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push_mid || push_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg   <= '0;
            confirmed_reg <= '0;
            rel_pend_reg  <= '0;
            repeating_reg <= '0;
            for (int i = 0; i < SCAN_KEYS; i++)
            begin
                tick_reg[i] <= kdb_pkg::DEBOUNCE_RST;
            end
        end
        else if (clr.clear)
        begin
            settled_reg   <= '0;
            confirmed_reg <= '0;
            rel_pend_reg  <= '0;
            repeating_reg <= '0;
            for (int i = 0; i < SCAN_KEYS; i++)
            begin
                tick_reg[i] <= clr.ticks;
            end
        end
        else if (step)
        begin
            settled_reg[kidx_reg]   <= s_next;
            confirmed_reg[kidx_reg] <= c_next;
            rel_pend_reg[kidx_reg]  <= rp_next;
            repeating_reg[kidx_reg] <= rep_next;
            tick_reg[kidx_reg]      <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            levels_reg <= q_levels;
        end
        if (step && fire)
        begin
            pend_key_reg  <= kn;
            pend_kind_reg <= kind;
        end
        if (push_mid || push_last)
        begin
            out_key_reg  <= pend_key_reg;
            out_kind_reg <= pend_kind_reg;
            out_last_reg <= push_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_index  = out_key_reg;
    assign event_kind = out_kind_reg;
    assign last_event = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/key_debounce_click_long_repeat_unit.sv
// top level of the key scanner: config registers, tick queue and key scan back end
// depends on kdb_pkg, kdb_regs, kdb_front, kdb_back
//
// usage:
//   input channel (in_valid / in_stall / pin_levels) carries one scan tick per
//   transaction; bit n is the raw pin of key n. a two-entry queue takes ticks
//   while the back end is busy and raises in_stall only when both entries are full.
//   output channel (out_valid / out_stall / key_index / event_kind / last_event)
//   carries one event per transaction, keys in ascending order, last_event set on
//   the final event of a tick; a tick with no event gives no transaction.
//   the back end scans min(NUM_KEYS, 8) keys, one per cycle unless a stalled
//   output holds the scan, passing each tick through take, scan and flush.
//   an event is held back until the next event of its tick is found, and shows
//   the cycle after that; the final one waits for the scan to end and leaves in flush.
//   a stalled output holds its event and freezes the scan at the next event.
//   config writes (cfg_valid / cfg_ready / cfg_index / cfg_data) are always
//   ready and are meant only while idle; a write to a listed register wipes all
//   key state and loads the debounce value into every counter.
//   reset: masks zero, debounce 5, long-click 100, repeat 20, keys released.
`default_nettype none

module key_debounce_click_long_repeat_unit #(
    parameter int NUM_KEYS = kdb_pkg::NUM_KEYS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [kdb_pkg::PIN_W-1:0]        pin_levels,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [kdb_pkg::KEY_W-1:0]             key_index,
    output logic [kdb_pkg::KIND_W-1:0]            event_kind,
    output logic                                  last_event,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kdb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kdb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    kdb_pkg::cfg_t             cfg;
    kdb_pkg::clear_t           clr;
    logic                      q_valid;
    logic [kdb_pkg::PIN_W-1:0] q_levels;
    logic                      q_pop;

    kdb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clr       (clr)
    );

    kdb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pin_levels (pin_levels),
        .active_low (cfg.active_low),
        .q_valid    (q_valid),
        .q_levels   (q_levels),
        .q_pop      (q_pop)
    );

    kdb_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .clr        (clr),
        .q_valid    (q_valid),
        .q_levels   (q_levels),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_index  (key_index),
        .event_kind (event_kind),
        .last_event (last_event)
    );

endmodule

`default_nettype wire
